// ===== design/kwl_pkg.sv =====
// ----------------------------------------------------------------------------
// kwl_pkg: keyword lexer shared types and tables
// Token codes, keyword spellings, character classes and the event word that
// passes from the front end to the token emitter.
// ----------------------------------------------------------------------------
package kwl_pkg;

	localparam int KEYWORD_CHARS_DEF = 9;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam int KW_COUNT    = 24;
	localparam int KW_MAX      = 9;
	localparam int CODE_W      = 6;
	localparam int KW_LEN_W    = 4;

	localparam logic [CODE_W-1:0] CODE_VALUE = 6'd0;

	localparam logic [CODE_W-1:0] CODE_DOT    = 6'd25;
	localparam logic [CODE_W-1:0] CODE_EQ     = 6'd26;
	localparam logic [CODE_W-1:0] CODE_COMMA  = 6'd27;
	localparam logic [CODE_W-1:0] CODE_PLUS   = 6'd28;
	localparam logic [CODE_W-1:0] CODE_MINUS  = 6'd29;
	localparam logic [CODE_W-1:0] CODE_STAR   = 6'd30;
	localparam logic [CODE_W-1:0] CODE_SLASH  = 6'd31;
	localparam logic [CODE_W-1:0] CODE_SEMI   = 6'd32;
	localparam logic [CODE_W-1:0] CODE_LBRACK = 6'd33;
	localparam logic [CODE_W-1:0] CODE_RBRACK = 6'd34;
	localparam logic [CODE_W-1:0] CODE_LPAREN = 6'd35;
	localparam logic [CODE_W-1:0] CODE_RPAREN = 6'd36;
	localparam logic [CODE_W-1:0] CODE_LBRACE = 6'd37;
	localparam logic [CODE_W-1:0] CODE_RBRACE = 6'd38;

	// spellings are right-justified: the last character sits in byte 0
	localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
		"public", "private", "protected", "static", "namespace", "using",
		"class", "method", "function", "return", "struct", "array",
		"while", "for", "if", "elif", "else", "new",
		"void", "int", "float", "string", "char", "var"
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd7, 4'd9, 4'd6, 4'd9, 4'd5,
		4'd5, 4'd6, 4'd8, 4'd6, 4'd6, 4'd5,
		4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd3,
		4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd3
	};

	// what one accepted character leaves for the emitter
	typedef struct packed {
		logic              word_v;
		logic [CODE_W-1:0] word_code;
		logic              punct_v;
		logic [CODE_W-1:0] punct_code;
	} kwl_event_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};
	endfunction

	// zero when the character is not punctuation
	function automatic logic [CODE_W-1:0] punct_code(input logic [7:0] c);
		logic [CODE_W-1:0] code;
		case (c)
			8'h2E: code = CODE_DOT;
			8'h3D: code = CODE_EQ;
			8'h2C: code = CODE_COMMA;
			8'h2B: code = CODE_PLUS;
			8'h2D: code = CODE_MINUS;
			8'h2A: code = CODE_STAR;
			8'h2F: code = CODE_SLASH;
			8'h3B: code = CODE_SEMI;
			8'h5B: code = CODE_LBRACK;
			8'h5D: code = CODE_RBRACK;
			8'h28: code = CODE_LPAREN;
			8'h29: code = CODE_RPAREN;
			8'h7B: code = CODE_LBRACE;
			8'h7D: code = CODE_RBRACE;
			default: code = CODE_VALUE;
		endcase
		return code;
	endfunction

endpackage

// ===== design/keyword_lexer_core.sv =====
// path: the first token of a character goes through the event queue, then the token output register
// throughput: one character per cycle while the event queue is not full; a character that
//   gives two tokens loads the token output register twice, absorbed by the event queue
// the single-port output register sets the sustained token rate at one per cycle while out_ready is high
// reset: asynchronous, clears the word length, queue pointers and output valid
// ----------------------------------------------------------------------------
// keyword_lexer_core: character lexer for a small keyword language
// Front end classifies words and punctuation, a queue decouples it from the
// token emitter.
// ----------------------------------------------------------------------------
module keyword_lexer_core #(
	parameter int KEYWORD_CHARS = kwl_pkg::KEYWORD_CHARS_DEF,
	parameter int QUEUE_DEPTH   = kwl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 source_byte,
	input  logic                       end_of_source,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kwl_pkg::CODE_W-1:0] token_code,
	output logic                       last_of_run
);
	import kwl_pkg::*;

	kwl_event_t push_word;
	kwl_event_t head_word;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	logic       accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	kwl_front #(
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.source_byte  (source_byte),
		.end_of_source(end_of_source),
		.push         (push),
		.event_word   (push_word)
	);

	kwl_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.full     (full),
		.pop      (pop),
		.head_word(head_word),
		.empty    (empty)
	);

	kwl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_word  (head_word),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_code (token_code),
		.last_of_run(last_of_run)
	);

endmodule

// ===== design/kwl_front.sv =====
// ----------------------------------------------------------------------------
// kwl_front: character intake and word classification
// Collects word characters, and on a word end looks the word up among the
// keywords, and pushes one event word into the queue per word end or punctuation.
// ----------------------------------------------------------------------------
module kwl_front #(
	parameter int KEYWORD_CHARS = kwl_pkg::KEYWORD_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         source_byte,
	input  logic               end_of_source,
	output logic               push,
	output kwl_pkg::kwl_event_t event_word
);
	import kwl_pkg::*;

	localparam int LEN_W = $clog2(KEYWORD_CHARS + 2);
	localparam logic [LEN_W-1:0] LEN_STORE = LEN_W'(KEYWORD_CHARS);

	logic [7:0]       word_q [KEYWORD_CHARS];
	logic [LEN_W-1:0] word_len_q;

	logic [CODE_W-1:0] pcode;
	logic              ends_word;
	logic              is_word_char;
	logic [CODE_W-1:0] kw_code;

	always_comb begin
		pcode        = end_of_source ? CODE_VALUE : punct_code(source_byte);
		ends_word    = end_of_source || is_space(source_byte) || (pcode != CODE_VALUE);
		is_word_char = !ends_word;
	end

	// parallel compare against every keyword spelling
	always_comb begin
		logic hit;
		kw_code = CODE_VALUE;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (word_len_q == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_MAX; i++) begin
				if (i < int'(KW_LEN[k])) begin
					if (word_q[i] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i)*8 +: 8])
						hit = 1'b0;
				end
			end
			if (hit)
				kw_code = CODE_W'(k + 1);
		end
	end

	always_comb begin
		event_word.word_v     = ends_word && (word_len_q != '0);
		event_word.word_code  = kw_code;
		event_word.punct_v    = pcode != CODE_VALUE;
		event_word.punct_code = pcode;
		push = accept && (event_word.word_v || event_word.punct_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q <= '0;
		end else if (accept) begin
			if (ends_word)
				word_len_q <= '0;
			else if (word_len_q <= LEN_STORE)
				word_len_q <= word_len_q + 1'b1;
		end
	end

	for (genvar i = 0; i < KEYWORD_CHARS; i++) begin : g_char
		always_ff @(posedge clk) begin
			if (accept && is_word_char && (word_len_q == LEN_W'(i)))
				word_q[i] <= source_byte;
		end
	end

endmodule

// ===== design/kwl_queue.sv =====
// ----------------------------------------------------------------------------
// kwl_queue: event queue between front end and emitter
// Small circular buffer of event words with full and empty flags.
// ----------------------------------------------------------------------------
module kwl_queue #(
	parameter int DEPTH = kwl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kwl_pkg::kwl_event_t push_word,
	output logic                full,
	input  logic                pop,
	output kwl_pkg::kwl_event_t head_word,
	output logic                empty
);
	import kwl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	kwl_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = count_q == CNT_FULL;
	assign empty     = count_q == '0;
	assign head_word = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/kwl_back.sv =====
// ----------------------------------------------------------------------------
// kwl_back: token emitter
// Turns each queued event into one or two tokens held in an output register,
// marking the final token of the event.
// ----------------------------------------------------------------------------
module kwl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kwl_pkg::kwl_event_t   head_word,
	input  logic                  empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [kwl_pkg::CODE_W-1:0] token_code,
	output logic                  last_of_run
);
	import kwl_pkg::*;

	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic              last_q;
	logic              punct_next_q;  // word token of the head already sent

	logic              load;
	logic              send_word;
	logic              next_punct;
	logic [CODE_W-1:0] code_d;
	logic              last_d;

	always_comb begin
		load       = !empty && (!out_valid_q || out_ready);
		send_word  = head_word.word_v && !punct_next_q;
		next_punct = send_word && head_word.punct_v;
		code_d     = send_word ? head_word.word_code : head_word.punct_code;
		last_d     = !next_punct;
		pop        = load && !next_punct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			punct_next_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q  <= 1'b1;
				punct_next_q <= next_punct;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code_d;
			last_q <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_code  = code_q;
	assign last_of_run = last_q;

endmodule

// ===== bench/tb_keyword_lexer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyword_lexer_core: self-checking bench for the keyword lexer
// Feeds a character stream of keywords, near-miss keywords, identifiers,
// raw byte words, punctuation, whitespace and end flags, with random noise.
// A scoreboard predicts each token and checks the token stream in order.
// ----------------------------------------------------------------------------
module tb_keyword_lexer_core;
	import kwl_pkg::*;

	localparam int          KEYWORD_CHARS = KEYWORD_CHARS_DEF;
	localparam int          ITEM_TARGET   = 850;
	localparam int unsigned PRESSURE_AT   = 150;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int          DRAIN_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} src_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} token_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [7:0]        source_byte   = 8'h00;
	logic              end_of_source = 1'b0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic [CODE_W-1:0] token_code;
	logic              last_of_run;

	string kw_names [KW_COUNT] = '{
		"public", "private", "protected", "static", "namespace", "using",
		"class", "method", "function", "return", "struct", "array",
		"while", "for", "if", "elif", "else", "new",
		"void", "int", "float", "string", "char", "var"
	};
	// in token code order, starting at the dot
	logic [7:0] punct_set [14] = '{
		8'h2E, 8'h3D, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h2F,
		8'h3B, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D
	};
	logic [7:0] blank_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};

	src_item_t   source_items [$];
	token_t      pending_tokens [$];
	logic [7:0]  word_buf [KEYWORD_CHARS];
	logic [3:0]  word_len = 4'd0;

	src_item_t   next_item;
	token_t      want;
	int unsigned gap_left     = 0;
	int unsigned items_sent   = 0;
	int unsigned ready_hold   = 0;
	int unsigned hold_cycles  = 0;
	int unsigned tokens_taken = 0;
	int unsigned idle_cycles  = 0;
	int unsigned error_count  = 0;

	keyword_lexer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_code    (token_code),
		.last_of_run   (last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic bit blank_char(logic [7:0] c);
		for (int i = 0; i < 6; i++)
			if (blank_set[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int punct_index(logic [7:0] c);
		for (int i = 0; i < 14; i++)
			if (punct_set[i] == c)
				return i;
		return -1;
	endfunction

	function automatic logic [CODE_W-1:0] token_for_word();
		bit hit;
		if (word_len > KEYWORD_CHARS)
			return CODE_VALUE;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (kw_names[k].len() == int'(word_len)) begin
				hit = 1'b1;
				for (int i = 0; i < int'(word_len); i++)
					if (word_buf[i] != 8'(kw_names[k][i]))
						hit = 1'b0;
				if (hit)
					return CODE_W'(k + 1);
			end
		end
		return CODE_VALUE;
	endfunction

	// one accepted character: update the pending word, queue its tokens
	task automatic lex_char(logic [7:0] c, logic eos);
		int                p;
		bit                word_done;
		bit                punct_done;
		logic [CODE_W-1:0] wcode;
		p          = punct_index(c);
		word_done  = 1'b0;
		punct_done = !eos && p >= 0;
		wcode      = CODE_VALUE;
		if (eos || blank_char(c) || p >= 0) begin
			if (word_len != 0) begin
				wcode     = token_for_word();
				word_done = 1'b1;
				word_len  = 4'd0;
			end
		end else begin
			if (word_len < KEYWORD_CHARS)
				word_buf[word_len] = c;
			// saturates one past the keyword limit
			if (word_len <= KEYWORD_CHARS)
				word_len = word_len + 4'd1;
		end
		if (word_done)
			pending_tokens.push_back('{code: wcode, last: !punct_done});
		if (punct_done)
			pending_tokens.push_back('{code: CODE_DOT + CODE_W'(p), last: 1'b1});
	endtask

	function automatic logic [7:0] random_word_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (blank_char(c) || punct_index(c) >= 0);
		return c;
	endfunction

	// runs of no idling, heavy idling and sparse idling
	function automatic int unsigned pause_for(int unsigned n);
		case ((n / 60) % 3)
			0: return 0;
			1: return $urandom_range(0, 19);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	task automatic push_char(logic [7:0] c, logic eos);
		source_items.push_back('{ch: c, eos: eos});
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(8'(s[i]), 1'b0);
	endtask

	initial begin
		string word;
		int    n;
		int    pos;

		// end flag with nothing pending, byte must be ignored
		push_char(8'hA5, 1'b1);
		push_text("namespace.");
		// null and high bytes form a value word, flushed by the end flag
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b0);
		push_char(8'h2E, 1'b1);
		// one past the keyword limit
		push_text("protectedx ");

		while (source_items.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				case ($urandom_range(0, 3))
					0: push_text(kw_names[$urandom_range(0, KW_COUNT - 1)]);
					1: begin
						word = kw_names[$urandom_range(0, KW_COUNT - 1)];
						pos  = $urandom_range(0, word.len() - 1);
						case ($urandom_range(0, 2))
							0: word = word.substr(0, word.len() - 2);
							1: word.putc(pos, 8'(8'h61 + $urandom_range(0, 25)));
							default: word = {word, "s"};
						endcase
						push_text(word);
					end
					2: begin
						n = $urandom_range(1, 12);
						repeat (n) push_char(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
					end
					default: begin
						n = $urandom_range(1, 12);
						repeat (n) push_char(random_word_byte(), 1'b0);
					end
				endcase
				case ($urandom_range(0, 3))
					0: repeat ($urandom_range(1, 2)) push_char(blank_set[$urandom_range(0, 5)], 1'b0);
					1: push_char(punct_set[$urandom_range(0, 13)], 1'b0);
					2: push_char(8'($urandom_range(0, 255)), 1'b1);
					default: begin
						push_char(punct_set[$urandom_range(0, 13)], 1'b0);
						push_char(blank_set[$urandom_range(0, 5)], 1'b0);
					end
				endcase
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (source_items.size() != 0 || in_valid)
			@(negedge clk);
		while (pending_tokens.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("tb_keyword_lexer_core: done, clean");
		else
			$display("tb_keyword_lexer_core: done, errors");
		$finish;
	end

	// character driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				lex_char(source_byte, end_of_source);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (source_items.size() != 0) begin
					next_item = source_items.pop_front();
					in_valid      <= 1'b1;
					source_byte   <= next_item.ch;
					end_of_source <= next_item.eos;
					gap_left      <= pause_for(items_sent);
					items_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// token monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("token %0d with none expected", token_code));
			end else begin
				want = pending_tokens.pop_front();
				if (token_code !== want.code)
					report_mismatch($sformatf("token_code %0d, expected %0d",
						token_code, want.code));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b (code %0d)",
						last_of_run, want.last, want.code));
			end
			// one long hold-off lets the input side back up
			hold_cycles = (tokens_taken == PRESSURE_AT) ? LONG_HOLD : pause_for(tokens_taken);
			tokens_taken++;
			if (hold_cycles != 0) begin
				out_ready  <= 1'b0;
				ready_hold <= hold_cycles;
			end
		end else if (ready_hold > 1) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_hold <= 0;
			out_ready  <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("tb_keyword_lexer_core: done, errors");
				$finish;
			end
		end
	end

endmodule
